### sv/sacl_pkg.sv
package sacl_pkg;

  localparam int unsigned TOTAL_LINES_DEF = 256;
  localparam int unsigned MAX_WAYS_DEF    = 8;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned AGE_W  = 3;
  localparam int unsigned WAY_W  = 3;
  localparam int unsigned CFG_W  = 2;
  localparam int unsigned CNT_W  = 32;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  typedef struct packed {
    logic              hit;
    logic [WAY_W-1:0]  way_used;
    logic              evicted;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  access_total;
  } rsp_t;

  // index width for n entries, at least one bit
  function automatic int unsigned idx_w(int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

### sv/sacl_req_if.sv
interface sacl_req_if;
  import sacl_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] block_address;

  modport source (output valid, output block_address, input ready);
  modport sink   (input valid, input block_address, output ready);
endinterface

### sv/sacl_rsp_if.sv
interface sacl_rsp_if;
  import sacl_pkg::*;

  logic             valid;
  logic             ready;
  logic             hit;
  logic [WAY_W-1:0] way_used;
  logic             evicted;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] access_total;

  modport source (output valid, output hit, output way_used, output evicted,
                  output hit_total, output access_total, input ready);
  modport sink   (input valid, input hit, input way_used, input evicted,
                  input hit_total, input access_total, output ready);
endinterface

### sv/set_assoc_cache_lru.sv
// Set-associative cache tag tracker with LRU replacement. Each request has a read
// step, which reads the row of the tag RAM that holds the addressed set, and a
// compare step, which compares all ways, picks the hit, empty or victim way, updates
// the age ranks and writes the row back. The tag RAM read is registered, so the
// row can be compared only after it is read, and the next read waits for the
// write-back, so a new request is not accepted until the last one is written back.
// The result sits in an output
// register; the next request is taken while it waits, and the write-back cycle
// holds only while that register is still full. Tags and ages live in a RAM of
// TOTAL_LINES/MAX_WAYS rows of MAX_WAYS lines; valid bits are flops cleared by
// reset, so the block is ready right after reset with no clearing pass. The way
// count follows ways_log2 (capped at MAX_WAYS) and may be changed only while idle;
// lines are kept as they stand across a change. Hit and access counts saturate.
module set_assoc_cache_lru #(
  parameter int unsigned TOTAL_LINES = sacl_pkg::TOTAL_LINES_DEF,
  parameter int unsigned MAX_WAYS    = sacl_pkg::MAX_WAYS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [sacl_pkg::CFG_W-1:0] cfg_wdata_i,
  sacl_req_if.sink                   req_i,
  sacl_rsp_if.source                 rsp_o
);
  import sacl_pkg::*;

  localparam int unsigned LOG_MW    = $clog2(MAX_WAYS);
  localparam int unsigned SLOT_W    = idx_w(MAX_WAYS);
  localparam int unsigned ROWS      = TOTAL_LINES / MAX_WAYS;
  localparam int unsigned ROW_IDX_W = idx_w(ROWS);
  localparam int unsigned LINE_W    = $clog2(TOTAL_LINES);
  localparam int unsigned SLOT_BITS = ADDR_W + AGE_W;
  localparam int unsigned ROW_BITS  = MAX_WAYS * SLOT_BITS;

  state_e                  state_q, state_d;
  logic [CFG_W-1:0]        cfg_q;
  logic [ADDR_W-1:0]       addr_q, addr_d;
  logic [TOTAL_LINES-1:0]  valid_q, valid_d;
  logic [CNT_W-1:0]        hits_q, hits_d;
  logic [CNT_W-1:0]        accs_q, accs_d;
  logic                    out_valid_q, out_valid_d;
  rsp_t                    out_q, out_d;

  logic [1:0]              wl_eff;
  logic [SLOT_W-1:0]       slot_mask;
  logic [LINE_W-1:0]       req_line, cur_line;
  logic [ROW_IDX_W-1:0]    req_row, cur_row;
  logic [SLOT_W-1:0]       col_base;

  logic                    ram_re, ram_we;
  logic [ROW_BITS-1:0]     row_rdata, row_wdata;

  logic [ADDR_W-1:0]       slot_addr [MAX_WAYS];
  logic [AGE_W-1:0]        slot_age  [MAX_WAYS];
  logic [MAX_WAYS-1:0]     slot_vld, in_set, match, empty, is_max;
  logic                    hit, found;
  logic [SLOT_W-1:0]       hit_j, empty_j, victim_j, sel_j;
  logic [AGE_W-1:0]        thresh;
  logic [LINE_W-1:0]       sel_line;

  // way count capped by the row width
  assign wl_eff    = (int'(cfg_q) > LOG_MW) ? 2'(LOG_MW) : cfg_q;
  assign slot_mask = SLOT_W'((32'd1 << wl_eff) - 32'd1);

  // first line of the set: (addr mod sets) * ways == (addr << log2 ways) mod lines
  assign req_line  = req_i.block_address[LINE_W-1:0] << wl_eff;
  assign cur_line  = addr_q[LINE_W-1:0] << wl_eff;
  assign req_row   = ROW_IDX_W'(req_line >> LOG_MW);
  assign cur_row   = ROW_IDX_W'(cur_line >> LOG_MW);
  assign col_base  = SLOT_W'(cur_line & LINE_W'(MAX_WAYS - 1));

  sacl_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (ROWS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cur_row),
    .wdata_i (row_wdata),
    .re_i    (ram_re),
    .raddr_i (req_row),
    .rdata_o (row_rdata)
  );

  // set lookup, replacement choice and age update
  always_comb begin
    slot_vld = valid_q[int'(cur_row) * MAX_WAYS +: MAX_WAYS];
    for (int j = 0; j < MAX_WAYS; j++) begin
      slot_addr[j] = row_rdata[j * SLOT_BITS +: ADDR_W];
      slot_age[j]  = row_rdata[j * SLOT_BITS + ADDR_W +: AGE_W];
      in_set[j]    = ((SLOT_W'(j) & ~slot_mask) == col_base);
      match[j]     = in_set[j] && slot_vld[j] && (slot_addr[j] == addr_q);
      empty[j]     = in_set[j] && !slot_vld[j];
    end

    // lowest way holding the highest age
    for (int j = 0; j < MAX_WAYS; j++) begin
      is_max[j] = in_set[j];
      for (int i = 0; i < MAX_WAYS; i++) begin
        if (in_set[i] && (i < j) && (slot_age[i] >= slot_age[j])) begin
          is_max[j] = 1'b0;
        end
        if (in_set[i] && (i > j) && (slot_age[i] > slot_age[j])) begin
          is_max[j] = 1'b0;
        end
      end
    end

    hit      = |match;
    found    = |empty;
    hit_j    = '0;
    empty_j  = '0;
    victim_j = '0;
    for (int j = MAX_WAYS - 1; j >= 0; j--) begin
      if (match[j]) begin
        hit_j = SLOT_W'(j);
      end
      if (empty[j]) begin
        empty_j = SLOT_W'(j);
      end
      if (is_max[j]) begin
        victim_j = SLOT_W'(j);
      end
    end

    if (hit) begin
      sel_j  = hit_j;
      thresh = slot_age[hit_j];
    end else if (found) begin
      sel_j  = empty_j;
      thresh = AGE_W'((4'd1 << wl_eff) - 4'd1);
    end else begin
      sel_j  = victim_j;
      thresh = slot_age[victim_j];
    end

    row_wdata = row_rdata;
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (SLOT_W'(j) == sel_j) begin
        row_wdata[j * SLOT_BITS +: ADDR_W]         = addr_q;
        row_wdata[j * SLOT_BITS + ADDR_W +: AGE_W] = '0;
      end else if (in_set[j] && slot_vld[j] && (slot_age[j] < thresh)) begin
        row_wdata[j * SLOT_BITS + ADDR_W +: AGE_W] = slot_age[j] + AGE_W'(1);
      end
    end

    sel_line = LINE_W'(int'(cur_row) * MAX_WAYS + int'(sel_j));
  end

  // sequencer: read row, then compare and write back
  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    valid_d     = valid_q;
    hits_d      = hits_q;
    accs_d      = accs_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    req_i.ready = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          ram_re  = 1'b1;
          addr_d  = req_i.block_address;
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // hold until the output register is free
        if (!out_valid_q || rsp_o.ready) begin
          ram_we            = 1'b1;
          valid_d[sel_line] = 1'b1;
          hits_d = (hit && (hits_q != '1)) ? hits_q + CNT_W'(1) : hits_q;
          accs_d = (accs_q != '1) ? accs_q + CNT_W'(1) : accs_q;
          out_d.hit          = hit;
          out_d.way_used     = WAY_W'(sel_j & slot_mask);
          out_d.evicted      = !hit && !found;
          out_d.hit_total    = hits_d;
          out_d.access_total = accs_d;
          out_valid_d        = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= '0;
      valid_q     <= '0;
      hits_q      <= '0;
      accs_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      hits_q      <= hits_d;
      accs_q      <= accs_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    out_q  <= out_d;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.hit          = out_q.hit;
  assign rsp_o.way_used     = out_q.way_used;
  assign rsp_o.evicted      = out_q.evicted;
  assign rsp_o.hit_total    = out_q.hit_total;
  assign rsp_o.access_total = out_q.access_total;

endmodule

### sv/sacl_ram.sv
module sacl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [sacl_pkg::idx_w(DEPTH)-1:0]    waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [sacl_pkg::idx_w(DEPTH)-1:0]    raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/sacl_checker.sv
module sacl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic        rsp_hit_i,
  input logic        rsp_evicted_i,
  input logic [31:0] rsp_hit_total_i,
  input logic [31:0] rsp_access_total_i
);

  // one lookup in flight: no transfer in the cycle right after one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request taken while a lookup is in flight");

  a_hits_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_hit_total_i <= rsp_access_total_i))
    else $error("hit count exceeds access count");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_hit_i) |-> !rsp_evicted_i)
    else $error("eviction reported on a hit");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_access_total_i != 32'd0))
    else $error("result carries a zero access count");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(rsp_access_total_i)))
    else $error("stalled result changed");

endmodule

bind set_assoc_cache_lru sacl_checker u_sacl_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_i.valid),
  .req_ready_i        (req_i.ready),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_hit_i          (rsp_o.hit),
  .rsp_evicted_i      (rsp_o.evicted),
  .rsp_hit_total_i    (rsp_o.hit_total),
  .rsp_access_total_i (rsp_o.access_total)
);

### tb/sv/set_assoc_cache_lru_checker.sv
module set_assoc_cache_lru_checker
  import sacl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  sacl_req_if              req,
  sacl_rsp_if              rsp,
  output int unsigned      fail_cnt_o,
  output int unsigned      pending_o,
  output int unsigned      lookup_cnt_o,
  output int unsigned      hit_cnt_o,
  output int unsigned      evict_cnt_o
);

  localparam int unsigned      LINES      = TOTAL_LINES_DEF;
  localparam int unsigned      REPORT_MAX = 10;
  localparam logic [CNT_W-1:0] CNT_MAX    = '1;

  logic [ADDR_W-1:0] line_tag   [LINES];
  logic              line_valid [LINES];
  logic [AGE_W-1:0]  line_age   [LINES];
  logic [CNT_W-1:0]  hits_q;
  logic [CNT_W-1:0]  accesses_q;
  logic [CFG_W-1:0]  ways_log2_q;
  rsp_t              expected_rsp_q [$];

  // Look up one block address, update tags and age ranks, return the result.
  function automatic rsp_t lru_lookup(input logic [ADDR_W-1:0] addr);
    int unsigned ways;
    int unsigned base;
    int unsigned way;
    int unsigned thresh;
    logic        hit;
    logic        found;
    rsp_t        res;
    ways = 1 << ways_log2_q;
    if (ways > MAX_WAYS_DEF) ways = MAX_WAYS_DEF;
    base  = (addr % (LINES / ways)) * ways;
    hit   = 1'b0;
    found = 1'b0;
    way   = 0;
    for (int unsigned k = 0; k < ways; k++) begin
      if (!hit && line_valid[base+k] && line_tag[base+k] == addr) begin
        hit = 1'b1;
        way = k;
      end
    end
    if (hit) begin
      thresh = line_age[base+way];
    end else begin
      for (int unsigned k = 0; k < ways; k++) begin
        if (!found && !line_valid[base+k]) begin
          found = 1'b1;
          way   = k;
        end
      end
      if (found) begin
        thresh = ways - 1;
      end else begin
        // oldest way wins, lowest index on a tie
        way    = 0;
        thresh = line_age[base];
        for (int unsigned k = 1; k < ways; k++) begin
          if (line_age[base+k] > thresh) begin
            thresh = line_age[base+k];
            way    = k;
          end
        end
      end
      line_tag[base+way]   = addr;
      line_valid[base+way] = 1'b1;
    end
    for (int unsigned k = 0; k < ways; k++) begin
      if (k != way && line_valid[base+k] && line_age[base+k] < thresh)
        line_age[base+k] = line_age[base+k] + 1'b1;
    end
    line_age[base+way] = '0;
    if (hit && hits_q != CNT_MAX) hits_q = hits_q + 1'b1;
    if (accesses_q != CNT_MAX) accesses_q = accesses_q + 1'b1;
    res.hit          = hit;
    res.way_used     = way[WAY_W-1:0];
    res.evicted      = !hit && !found;
    res.hit_total    = hits_q;
    res.access_total = accesses_q;
    return res;
  endfunction

  function automatic bit log_failure();
    fail_cnt_o++;
    return fail_cnt_o <= REPORT_MAX;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    rsp_t got;
    if (!rst_ni) begin
      for (int unsigned i = 0; i < LINES; i++) begin
        line_tag[i]   = '0;
        line_valid[i] = 1'b0;
        line_age[i]   = '0;
      end
      hits_q       = '0;
      accesses_q   = '0;
      ways_log2_q  = '0;
      expected_rsp_q.delete();
      fail_cnt_o   = 0;
      lookup_cnt_o = 0;
      hit_cnt_o    = 0;
      evict_cnt_o  = 0;
    end else begin
      if (cfg_we_i) ways_log2_q = cfg_wdata_i;
      if (req.valid && req.ready) begin
        want = lru_lookup(req.block_address);
        expected_rsp_q.push_back(want);
        lookup_cnt_o++;
        if (want.hit) hit_cnt_o++;
        if (want.evicted) evict_cnt_o++;
      end
      if (rsp.valid && rsp.ready) begin
        got.hit          = rsp.hit;
        got.way_used     = rsp.way_used;
        got.evicted      = rsp.evicted;
        got.hit_total    = rsp.hit_total;
        got.access_total = rsp.access_total;
        if (expected_rsp_q.size() == 0) begin
          if (log_failure())
            $display("[%0t] unexpected result: hit=%0b way=%0d evicted=%0b hits=%0d acc=%0d",
                     $time, got.hit, got.way_used, got.evicted, got.hit_total,
                     got.access_total);
        end else begin
          want = expected_rsp_q.pop_front();
          if (got.hit !== want.hit || got.way_used !== want.way_used ||
              got.evicted !== want.evicted || got.hit_total !== want.hit_total ||
              got.access_total !== want.access_total) begin
            if (log_failure())
              $display({"[%0t] mismatch: expected hit=%0b way=%0d evicted=%0b hits=%0d ",
                        "acc=%0d, got hit=%0b way=%0d evicted=%0b hits=%0d acc=%0d"},
                       $time, want.hit, want.way_used, want.evicted, want.hit_total,
                       want.access_total, got.hit, got.way_used, got.evicted,
                       got.hit_total, got.access_total);
          end
        end
      end
    end
    pending_o = expected_rsp_q.size();
  end

endmodule

### tb/sv/set_assoc_cache_lru_tb.sv
module set_assoc_cache_lru_tb;
  import sacl_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 88;
  localparam int unsigned IDLE_PCT     = 24;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  bit               calm = 1'b0;
  int unsigned      cycle_cnt = 0;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned lookup_cnt;
  int unsigned hit_cnt;
  int unsigned evict_cnt;

  logic [ADDR_W-1:0] recent [8];

  sacl_req_if req_if ();
  sacl_rsp_if rsp_if ();

  set_assoc_cache_lru i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  set_assoc_cache_lru_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req          (req_if),
    .rsp          (rsp_if),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending),
    .lookup_cnt_o (lookup_cnt),
    .hit_cnt_o    (hit_cnt),
    .evict_cnt_o  (evict_cnt)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    rsp_if.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Hold valid until the transfer, with random gaps before it.
  task automatic send_lookup(input logic [ADDR_W-1:0] addr);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.block_address <= addr;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    recent[$urandom_range(0, 7)] = addr;
  endtask

  // Drain all outstanding lookups, then write the way count.
  task automatic set_ways(input logic [CFG_W-1:0] ways_log2);
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ways_log2;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0]  phase_ways [PHASES];
    logic [23:0]       pool_tag [6];
    logic [7:0]        pool_low [4];
    logic [ADDR_W-1:0] addr;
    int unsigned       sel;
    phase_ways = '{2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd0, 2'd1, 2'd2};
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_wdata_i          <= '0;
    req_if.valid         <= 1'b0;
    req_if.block_address <= '0;
    for (int i = 0; i < 8; i++) recent[i] = $urandom();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_ways(2'd0);
    // Two ways: place block 0 in way 1 of set 0, behind block 128.
    set_ways(2'd1);
    send_lookup(32'd128);
    send_lookup(32'd0);
    send_lookup(32'd0);
    // One way: block 0 replaces 128 in line 0, leaving two copies of block 0.
    set_ways(2'd0);
    send_lookup(32'd0);
    // Two ways again: both ways match, the lower one must hit; then a tie victim.
    set_ways(2'd1);
    send_lookup(32'd0);
    send_lookup(32'd128);
    // Eight ways: fill one set, touch, then evict the oldest.
    set_ways(2'd3);
    for (int unsigned k = 0; k < 8; k++) send_lookup(32'd5 + 32'd32 * k);
    send_lookup(32'd5);
    send_lookup(32'd5 + 32'd256);
    send_lookup(32'hFFFF_FFFF);
    send_lookup(32'hFFFF_FFFF);
    send_lookup(32'h0000_0000);
    set_ways(2'd2);
    send_lookup(32'hFFFF_FFFF);
    send_lookup(32'hFFFF_FF3F);

    for (int unsigned p = 0; p < PHASES; p++) begin
      set_ways(phase_ways[p]);
      calm = (p == 3);
      for (int i = 0; i < 6; i++) pool_tag[i] = $urandom();
      for (int i = 0; i < 4; i++) pool_low[i] = $urandom_range(0, 255);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 45)
          addr = recent[$urandom_range(0, 7)];
        else if (sel < 75)
          addr = {pool_tag[$urandom_range(0, 5)], pool_low[$urandom_range(0, 3)]};
        else
          addr = $urandom();
        send_lookup(addr);
      end
      calm = 1'b0;
    end

    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);

    $display("Checked %0d lookups over way counts 1, 2, 4 and 8: %0d hits, %0d LRU evictions",
             lookup_cnt, hit_cnt, evict_cnt);
    $display("Included duplicate tags after a way change, victim ties, and stalls on both sides");
    if (fail_cnt == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
